FILE: sv/srpt_pkg.sv
// ----------------------------------------------------------------------------
// srpt_pkg: shared types and codes for the SQL response packet tracker
// Phase, response-kind and operation codes, plus the word formats that pass
// between the front classifier, the queue and the back tracker.
// ----------------------------------------------------------------------------
package srpt_pkg;

  // Largest legal column count in a result-set header.
  localparam int MAX_COLUMNS = 4096;

  localparam int CNT_W = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Depth of the front/back queue and of the result queue.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Tracker phases.
  localparam logic [3:0] PH_FIRST     = 4'd0;
  localparam logic [3:0] PH_FIELD     = 4'd1;
  localparam logic [3:0] PH_FIELD_EOF = 4'd2;
  localparam logic [3:0] PH_ROW       = 4'd3;
  localparam logic [3:0] PH_FIELDLIST = 4'd4;
  localparam logic [3:0] PH_STATS     = 4'd5;
  localparam logic [3:0] PH_FETCH     = 4'd6;
  localparam logic [3:0] PH_DONE      = 4'd7;
  localparam logic [3:0] PH_ERRPKT    = 4'd8;
  localparam logic [3:0] PH_ERROR     = 4'd9;

  // Input function codes.
  localparam logic [1:0] FN_START = 2'd0;
  localparam logic [1:0] FN_REQ   = 2'd1;
  localparam logic [1:0] FN_RESP  = 2'd2;

  // Command kinds on a start word.
  localparam logic [1:0] CMD_OTHER     = 2'd0;
  localparam logic [1:0] CMD_FIELDLIST = 2'd1;
  localparam logic [1:0] CMD_STATS     = 2'd2;
  localparam logic [1:0] CMD_FETCH     = 2'd3;

  // Response kinds.
  localparam logic [2:0] RK_DATA   = 3'd0;
  localparam logic [2:0] RK_OK     = 3'd1;
  localparam logic [2:0] RK_EOF    = 3'd2;
  localparam logic [2:0] RK_ERR    = 3'd3;
  localparam logic [2:0] RK_INFILE = 3'd4;
  localparam logic [2:0] RK_OTHER  = 3'd5;

  // Classified operations handed to the back end.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_REQ   = 2'd1;
  localparam logic [1:0] OP_RESP  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       init_phase;
    logic             leader;
    logic             cont;
    logic             trailer;
    logic [2:0]       kind;
    logic             more;
    logic             too_big;
    logic [CNT_W-1:0] count;
  } op_t;

  typedef struct packed {
    logic [3:0] tracker_state;
    logic       exp_resp;
    logic       exp_req;
    logic       exp_more;
    logic       req_ok;
    logic       data_only;
  } res_t;

endpackage

FILE: sv/srpt_front.sv
// ----------------------------------------------------------------------------
// srpt_front: input classifier
// Accepts words from the push side, decodes function and command, folds the
// unused response kinds and checks the column count, then queues the result.
// ----------------------------------------------------------------------------
module srpt_front import srpt_pkg::*; (
  input  logic             push,
  output logic             full,
  input  logic [1:0]       func,
  input  logic [1:0]       command_kind,
  input  logic             server_responds,
  input  logic             split_leader,
  input  logic             split_continuation,
  input  logic             split_trailer,
  input  logic [2:0]       response_kind,
  input  logic             more_results,
  input  logic [CNT_W-1:0] column_count,
  input  logic             q_full,
  output logic             q_push,
  output op_t              q_word
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_word = '0;
    unique case (func)
      FN_START: q_word.op = OP_START;
      FN_REQ:   q_word.op = OP_REQ;
      FN_RESP:  q_word.op = OP_RESP;
      default:  q_word.op = OP_NOP;
    endcase

    if (!server_responds) begin
      q_word.init_phase = PH_DONE;
    end else begin
      unique case (command_kind)
        CMD_FIELDLIST: q_word.init_phase = PH_FIELDLIST;
        CMD_STATS:     q_word.init_phase = PH_STATS;
        CMD_FETCH:     q_word.init_phase = PH_FETCH;
        default:       q_word.init_phase = PH_FIRST;
      endcase
    end

    // kinds past "other" carry no meaning; treat them as other
    q_word.kind    = (response_kind > RK_OTHER) ? RK_OTHER : response_kind;
    q_word.leader  = split_leader;
    q_word.cont    = split_continuation;
    q_word.trailer = split_trailer;
    q_word.more    = more_results;
    q_word.count   = column_count;
    q_word.too_big = 32'(column_count) > 32'(MAX_COLUMNS);
  end

endmodule

FILE: sv/srpt_queue.sv
// ----------------------------------------------------------------------------
// srpt_queue: front-to-back queue
// Short register queue of classified words between classifier and tracker.
// ----------------------------------------------------------------------------
module srpt_queue import srpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wr_word,
  output logic full,
  input  logic pop,
  output logic empty,
  output op_t  rd_word
);

  op_t                mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full    = count == Q_CNT_W'(Q_DEPTH);
  assign empty   = count == '0;
  assign rd_word = mem[rd_ptr];

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

FILE: sv/srpt_back.sv
// ----------------------------------------------------------------------------
// srpt_back: exchange tracker
// Applies one queued word per cycle, while the result queue has room, to the
// phase machine and column counters; results wait in a short queue for pop.
// ----------------------------------------------------------------------------
module srpt_back import srpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  op_t        q_word,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output res_t       res_word
);

  logic [3:0]       phase;
  logic [3:0]       phase_next;
  logic             split_pending;
  logic             split_pending_next;
  logic [CNT_W-1:0] columns_seen;
  logic [CNT_W-1:0] columns_seen_next;
  logic [CNT_W-1:0] columns_total;
  logic [CNT_W-1:0] columns_total_next;
  logic [CNT_W-1:0] seen_inc;

  res_t               oq [Q_DEPTH];
  logic [Q_PTR_W-1:0] owr;
  logic [Q_PTR_W-1:0] ord;
  logic [Q_CNT_W-1:0] ocnt;
  logic               ofull;
  logic               opop;
  logic               exec;
  res_t               res_next;

  assign ofull    = ocnt == Q_CNT_W'(Q_DEPTH);
  assign empty    = ocnt == '0;
  assign opop     = pop && !empty;
  assign exec     = !q_empty && !ofull;
  assign q_pop    = exec;
  assign res_word = oq[ord];
  assign seen_inc = (columns_seen < CNT_MAX) ? columns_seen + 1'b1 : columns_seen;

  always_comb begin
    phase_next         = phase;
    split_pending_next = split_pending;
    columns_seen_next  = columns_seen;
    columns_total_next = columns_total;

    case (q_word.op)
      OP_START: begin
        split_pending_next = q_word.leader;
        phase_next         = q_word.init_phase;
      end
      OP_REQ: begin
        if (!split_pending || !q_word.cont) begin
          phase_next = PH_ERROR;
        end
        if (q_word.trailer) begin
          split_pending_next = 1'b0;
        end
      end
      OP_RESP: begin
        if (!q_word.cont) begin
          if (q_word.kind == RK_ERR) begin
            phase_next = PH_ERRPKT;
          end else begin
            unique case (phase)
              PH_FIRST: begin
                if (q_word.kind == RK_DATA) begin
                  if (q_word.too_big) begin
                    phase_next = PH_ERROR;
                  end else begin
                    columns_seen_next  = '0;
                    columns_total_next = q_word.count;
                    phase_next         = PH_FIELD;
                  end
                end else if (q_word.kind == RK_OK) begin
                  phase_next = q_word.more ? PH_FIRST : PH_DONE;
                end else begin
                  phase_next = PH_ERROR;
                end
              end
              PH_FIELD: begin
                if (q_word.kind != RK_DATA) begin
                  phase_next = PH_ERROR;
                end else begin
                  columns_seen_next = seen_inc;
                  phase_next = (seen_inc == columns_total) ? PH_FIELD_EOF : PH_FIELD;
                end
              end
              PH_FIELD_EOF: phase_next = (q_word.kind == RK_EOF) ? PH_ROW : PH_ERROR;
              PH_ROW: begin
                if (q_word.kind == RK_DATA) begin
                  phase_next = PH_ROW;
                end else if (q_word.kind == RK_EOF) begin
                  phase_next = q_word.more ? PH_FIRST : PH_DONE;
                end else begin
                  phase_next = PH_ERROR;
                end
              end
              PH_FIELDLIST: begin
                if (q_word.kind == RK_DATA) begin
                  phase_next = PH_FIELDLIST;
                end else begin
                  phase_next = (q_word.kind == RK_EOF) ? PH_DONE : PH_ERROR;
                end
              end
              PH_STATS: phase_next = (q_word.kind == RK_DATA) ? PH_DONE : PH_ERROR;
              PH_FETCH: begin
                if (q_word.kind == RK_DATA) begin
                  phase_next = PH_FETCH;
                end else if (q_word.kind == RK_EOF) begin
                  phase_next = q_word.more ? PH_FETCH : PH_DONE;
                end else begin
                  phase_next = PH_ERROR;
                end
              end
              default: phase_next = PH_ERROR;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_next.tracker_state = phase_next;
    res_next.exp_resp      = !(phase_next == PH_DONE || phase_next == PH_ERRPKT ||
                               phase_next == PH_ERROR);
    res_next.exp_req       = split_pending_next;
    res_next.exp_more      = res_next.exp_resp || split_pending_next;
    res_next.req_ok        = phase_next != PH_ERROR;
    res_next.data_only     = phase_next == PH_FIELD || phase_next == PH_ROW ||
                             phase_next == PH_FIELDLIST || phase_next == PH_STATS ||
                             phase_next == PH_FETCH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      split_pending <= 1'b0;
      columns_seen  <= '0;
      columns_total <= '0;
    end else if (exec) begin
      phase         <= phase_next;
      split_pending <= split_pending_next;
      columns_seen  <= columns_seen_next;
      columns_total <= columns_total_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (exec) begin
      oq[owr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr  <= '0;
      ord  <= '0;
      ocnt <= '0;
    end else begin
      if (exec) begin
        owr <= (owr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : owr + 1'b1;
      end
      if (opop) begin
        ord <= (ord == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : ord + 1'b1;
      end
      case ({exec, opop})
        2'b10:   ocnt <= ocnt + 1'b1;
        2'b01:   ocnt <= ocnt - 1'b1;
        default: ocnt <= ocnt;
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (phase == PH_DONE && !split_pending && empty))
    else $error("tracker not idle after reset");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_ERROR)
    else $error("phase code out of range");

  a_start_split: assert property (@(posedge clk) disable iff (rst)
    (exec && q_word.op == OP_START) |=> split_pending == $past(q_word.leader))
    else $error("start word did not load split flag");

  a_res_count: assert property (@(posedge clk) disable iff (rst)
    ocnt <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue count out of range");

endmodule

FILE: sv/sql_response_packet_tracker.sv
// ----------------------------------------------------------------------------
// sql_response_packet_tracker: SQL exchange tracker, top level
// Follows one client-server exchange from pre-classified packets and reports
// the tracker state and expectation flags after every word.
//
//   channel | handshake        | payload
//   --------+------------------+---------------------------------------------
//   input   | push / full      | func, command_kind, server_responds,
//           |                  | split_leader, split_continuation,
//           |                  | split_trailer, response_kind, more_results,
//           |                  | column_count
//   result  | empty / pop      | tracker_state, expecting_response,
//           |                  | expecting_request, expecting_more,
//           |                  | request_ok, data_only_next
//
// One word in, one word out; sustained rate is one word per clock while the
// pop side keeps up. A word lands in the front queue when it is accepted;
// the back end applies it and writes the result word into the result queue,
// from which it can be popped. The back end's phase machine updates once
// per cycle while it has a word and room for a result, and sets the rate.
// Reset (rst, synchronous) puts the tracker in the done phase and empties both
// queues. A stalled pop side fills the result queue, then the front queue,
// then raises full; the front keeps taking words until both are full.
// ----------------------------------------------------------------------------
module sql_response_packet_tracker import srpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       func,
  input  logic [1:0]       command_kind,
  input  logic             server_responds,
  input  logic             split_leader,
  input  logic             split_continuation,
  input  logic             split_trailer,
  input  logic [2:0]       response_kind,
  input  logic             more_results,
  input  logic [CNT_W-1:0] column_count,
  output logic             empty,
  input  logic             pop,
  output logic [3:0]       tracker_state,
  output logic             expecting_response,
  output logic             expecting_request,
  output logic             expecting_more,
  output logic             request_ok,
  output logic             data_only_next
);

  // front -> queue -> back
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  op_t  q_wr_word;
  op_t  q_rd_word;
  res_t res_word;

  srpt_front u_front (
    .push               (push),
    .full               (full),
    .func               (func),
    .command_kind       (command_kind),
    .server_responds    (server_responds),
    .split_leader       (split_leader),
    .split_continuation (split_continuation),
    .split_trailer      (split_trailer),
    .response_kind      (response_kind),
    .more_results       (more_results),
    .column_count       (column_count),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_word             (q_wr_word)
  );

  srpt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_word (q_wr_word),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_word (q_rd_word)
  );

  // back end owns the phase machine and the result queue
  srpt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_word   (q_rd_word),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .res_word (res_word)
  );

  assign tracker_state      = res_word.tracker_state;
  assign expecting_response = res_word.exp_resp;
  assign expecting_request  = res_word.exp_req;
  assign expecting_more     = res_word.exp_more;
  assign request_ok         = res_word.req_ok;
  assign data_only_next     = res_word.data_only;

endmodule

FILE: sim/sql_response_packet_tracker_test.sv
// ----------------------------------------------------------------------------
// sql_response_packet_tracker_test: self-checking bench for the exchange tracker
// Drives classified packet words through the push/full side and checks every
// tracker report against an in-bench copy of the phase machine. A short
// directed table comes first, then two short column walks and the header
// limit, then phase-following random traffic under four idle/stall mixes.
// ----------------------------------------------------------------------------
module sql_response_packet_tracker_test;
  import srpt_pkg::*;

  // Codes the package leaves unnamed.
  localparam logic [1:0] FN_IDLE  = 2'd3;  // unused func, only reports the state
  localparam logic [2:0] RK_SPARE = 3'd6;  // unknown kind, acts as "other"

  localparam int NUM_DIRECTED  = 25;
  localparam int WALK_COLS     = 24;       // columns in the walked result sets
  localparam int RANDOM_WORDS  = 260;      // per idle/stall mix
  localparam int TAIL_CYCLES   = 8;        // idle tail before the final summary
  localparam int CYCLE_LIMIT   = 40000;    // timeout guard for the whole run

  // One input word, field for field in port order.
  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       cmd;
    logic             responds;
    logic             leader;
    logic             cont;
    logic             trailer;
    logic [2:0]       kind;
    logic             more;
    logic [CNT_W-1:0] count;
  } pkt_t;

  // Directed row: the word, and a hand-typed report where one is obvious.
  typedef struct packed {
    pkt_t pkt;
    logic fixed;
    res_t want;
  } step_t;

  localparam res_t NO_WANT = '0;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             pop = 1'b0;
  logic             full;
  logic             empty;
  logic [1:0]       func = FN_START;
  logic [1:0]       command_kind = CMD_OTHER;
  logic             server_responds = 1'b0;
  logic             split_leader = 1'b0;
  logic             split_continuation = 1'b0;
  logic             split_trailer = 1'b0;
  logic [2:0]       response_kind = RK_DATA;
  logic             more_results = 1'b0;
  logic [CNT_W-1:0] column_count = '0;
  logic [3:0]       tracker_state;
  logic             expecting_response;
  logic             expecting_request;
  logic             expecting_more;
  logic             request_ok;
  logic             data_only_next;

  // Bench copy of the tracker state.
  logic [3:0]       trk_phase = PH_DONE;
  logic             trk_split = 1'b0;
  logic [CNT_W-1:0] trk_cols_seen = '0;
  logic [CNT_W-1:0] trk_cols_total = '0;

  res_t reports_due[$];   // tracker reports still owed by the block, oldest first
  res_t oldest;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_in = 0;
  int reports_out = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Hand-written opening: nop, late response, split request, a short result
  // set, the three special commands, the oversized header, an error packet,
  // a stray request packet, an unknown response kind and a split start word.
  step_t directed_tab [NUM_DIRECTED] = '{
    '{'{FN_IDLE, CMD_FETCH, 1'b1, 1'b1, 1'b1, 1'b1, 3'd7, 1'b1, 13'h1FFF}, 1'b1,
      '{PH_DONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b1,
      '{PH_ERROR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{FN_START, CMD_OTHER, 1'b1, 1'b1, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b1,
      '{PH_FIRST, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{'{FN_REQ, CMD_OTHER, 1'b0, 1'b0, 1'b1, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b1, 1'b0, RK_OK, 1'b0, 13'd5}, 1'b0, NO_WANT},
    '{'{FN_REQ, CMD_OTHER, 1'b0, 1'b0, 1'b1, 1'b1, RK_DATA, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd2}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_EOF, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_EOF, 1'b1, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_OK, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_START, CMD_FIELDLIST, 1'b1, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b0,
      NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_EOF, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_START, CMD_STATS, 1'b1, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_SPARE, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_START, CMD_FETCH, 1'b1, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_EOF, 1'b1, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_EOF, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_START, CMD_OTHER, 1'b1, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'h1FFF}, 1'b1,
      '{PH_ERROR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{FN_START, CMD_OTHER, 1'b1, 1'b0, 1'b0, 1'b0, RK_DATA, 1'b0, 13'd0}, 1'b0, NO_WANT},
    '{'{FN_RESP, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b0, RK_ERR, 1'b1, 13'd0}, 1'b1,
      '{PH_ERRPKT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{FN_REQ, CMD_OTHER, 1'b0, 1'b0, 1'b0, 1'b1, RK_DATA, 1'b0, 13'd0}, 1'b1,
      '{PH_ERROR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{FN_START, CMD_OTHER, 1'b1, 1'b1, 1'b0, 1'b0, RK_INFILE, 1'b0, 13'd0}, 1'b0,
      NO_WANT}
  };

  sql_response_packet_tracker u_top (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .func               (func),
    .command_kind       (command_kind),
    .server_responds    (server_responds),
    .split_leader       (split_leader),
    .split_continuation (split_continuation),
    .split_trailer      (split_trailer),
    .response_kind      (response_kind),
    .more_results       (more_results),
    .column_count       (column_count),
    .empty              (empty),
    .pop                (pop),
    .tracker_state      (tracker_state),
    .expecting_response (expecting_response),
    .expecting_request  (expecting_request),
    .expecting_more     (expecting_more),
    .request_ok         (request_ok),
    .data_only_next     (data_only_next)
  );

  always #2 clk = ~clk;

  // Steps the bench tracker by one accepted word and returns its report.
  function automatic res_t track_packet(pkt_t p);
    res_t r;
    case (p.func)
      FN_START: begin
        trk_split = p.leader;
        if (!p.responds) begin
          trk_phase = PH_DONE;
        end else begin
          case (p.cmd)
            CMD_FIELDLIST: trk_phase = PH_FIELDLIST;
            CMD_STATS:     trk_phase = PH_STATS;
            CMD_FETCH:     trk_phase = PH_FETCH;
            default:       trk_phase = PH_FIRST;
          endcase
        end
      end
      FN_REQ: begin
        // stray request packet errors out, but a trailer still closes the split
        if (!trk_split || !p.cont) trk_phase = PH_ERROR;
        if (p.trailer) trk_split = 1'b0;
      end
      FN_RESP: begin
        // split continuation of a response: nothing moves
        if (!p.cont) begin
          if (p.kind == RK_ERR) begin
            trk_phase = PH_ERRPKT;
          end else begin
            case (trk_phase)
              PH_FIRST: begin
                if (p.kind == RK_DATA) begin
                  if (p.count > MAX_COLUMNS) begin
                    trk_phase = PH_ERROR;
                  end else begin
                    trk_cols_seen = '0;
                    trk_cols_total = p.count;
                    trk_phase = PH_FIELD;
                  end
                end else if (p.kind == RK_OK) begin
                  trk_phase = p.more ? PH_FIRST : PH_DONE;
                end else begin
                  trk_phase = PH_ERROR;
                end
              end
              PH_FIELD: begin
                if (p.kind != RK_DATA) begin
                  trk_phase = PH_ERROR;
                end else begin
                  if (trk_cols_seen != CNT_MAX) trk_cols_seen = trk_cols_seen + 1'b1;
                  trk_phase = (trk_cols_seen == trk_cols_total) ? PH_FIELD_EOF : PH_FIELD;
                end
              end
              PH_FIELD_EOF: trk_phase = (p.kind == RK_EOF) ? PH_ROW : PH_ERROR;
              PH_ROW: begin
                if (p.kind == RK_DATA) trk_phase = PH_ROW;
                else if (p.kind == RK_EOF) trk_phase = p.more ? PH_FIRST : PH_DONE;
                else trk_phase = PH_ERROR;
              end
              PH_FIELDLIST: begin
                if (p.kind == RK_DATA) trk_phase = PH_FIELDLIST;
                else trk_phase = (p.kind == RK_EOF) ? PH_DONE : PH_ERROR;
              end
              PH_STATS: trk_phase = (p.kind == RK_DATA) ? PH_DONE : PH_ERROR;
              PH_FETCH: begin
                if (p.kind == RK_DATA) trk_phase = PH_FETCH;
                else if (p.kind == RK_EOF) trk_phase = p.more ? PH_FETCH : PH_DONE;
                else trk_phase = PH_ERROR;
              end
              // done, error packet, error: any further response is an error
              default: trk_phase = PH_ERROR;
            endcase
          end
        end
      end
      default: ;  // unused func: report only
    endcase
    r.tracker_state = trk_phase;
    r.exp_resp  = !(trk_phase == PH_DONE || trk_phase == PH_ERRPKT || trk_phase == PH_ERROR);
    r.exp_req   = trk_split;
    r.exp_more  = r.exp_resp || trk_split;
    r.req_ok    = (trk_phase != PH_ERROR);
    r.data_only = (trk_phase == PH_FIELD) || (trk_phase == PH_ROW) ||
                  (trk_phase == PH_FIELDLIST) || (trk_phase == PH_STATS) ||
                  (trk_phase == PH_FETCH);
    return r;
  endfunction

  function automatic pkt_t start_word(logic [1:0] cmd);
    pkt_t p;
    p = '0;
    p.func = FN_START;
    p.cmd = cmd;
    p.responds = 1'b1;
    return p;
  endfunction

  function automatic pkt_t resp_word(logic [2:0] kind, logic more, logic [CNT_W-1:0] count);
    pkt_t p;
    p = '0;
    p.func = FN_RESP;
    p.kind = kind;
    p.more = more;
    p.count = count;
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH @%0d report %0d: %s", cycle_count, reports_out, msg);
  endtask

  task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Offers one word, with random idle cycles first, and holds it until taken.
  // The report is predicted on acceptance; a directed row may override it.
  task automatic send_packet(input pkt_t p, input logic fixed, input res_t want);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push               <= 1'b1;
    func               <= p.func;
    command_kind       <= p.cmd;
    server_responds    <= p.responds;
    split_leader       <= p.leader;
    split_continuation <= p.cont;
    split_trailer      <= p.trailer;
    response_kind      <= p.kind;
    more_results       <= p.more;
    column_count       <= p.count;
    @(posedge clk);
    while (full) @(posedge clk);
    r = track_packet(p);
    reports_due.push_back(fixed ? want : r);
    words_in++;
  endtask

  // Random traffic that mostly follows the exchange the tracker is in, so
  // result sets, split requests and the special commands run to completion;
  // about one word in ten is pure noise and a few are error, infile or split
  // continuation responses. Ends by draining every owed report.
  task automatic run_traffic(input int n_words, input int idle_pct, input int stall_pct);
    pkt_t        w;
    logic [31:0] raw;
    int          roll;
    int          sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_words) begin
      raw = $urandom;
      w = raw[$bits(pkt_t)-1:0];
      roll = $urandom_range(99);
      if (roll >= 10) begin
        w.func = FN_RESP;
        w.cont = 1'b0;
        if (roll < 16) begin
          case ($urandom_range(2))
            0:       w.cont = 1'b1;
            1:       w.kind = RK_ERR;
            default: w.kind = RK_INFILE;
          endcase
        end else if (trk_split && roll < 60) begin
          w.func = FN_REQ;
          w.cont = 1'b1;
          w.trailer = ($urandom_range(2) == 0);
        end else begin
          case (trk_phase)
            PH_FIRST: begin
              if ($urandom_range(3) != 0) begin
                w.kind = RK_DATA;
                // mostly tiny result sets; now and then any 13-bit count
                if ($urandom_range(19) != 0) w.count = CNT_W'($urandom_range(4, 1));
              end else begin
                w.kind = RK_OK;
              end
            end
            PH_FIELD:     w.kind = RK_DATA;
            PH_FIELD_EOF: w.kind = RK_EOF;
            PH_STATS:     w.kind = RK_DATA;
            PH_ROW, PH_FIELDLIST, PH_FETCH:
              w.kind = ($urandom_range(2) != 0) ? RK_DATA : RK_EOF;
            default: begin
              w.func = FN_START;
              w.responds = ($urandom_range(9) != 0);
              w.leader = ($urandom_range(3) == 0);
            end
          endcase
        end
      end
      send_packet(w, 1'b0, NO_WANT);
      if (!(w.func == FN_IDLE || (w.func == FN_RESP && w.cont))) sent++;
    end
    // hold off until the block has handed back everything
    push <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // Result side: check the report taken at this edge, then pick the next pop.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        reports_out++;
        if (reports_due.size() == 0) begin
          report_mismatch($sformatf("unexpected report, state %0d", tracker_state));
        end else begin
          oldest = reports_due.pop_front();
          check_field("tracker_state", tracker_state, oldest.tracker_state);
          check_field("expecting_response", 4'(expecting_response), 4'(oldest.exp_resp));
          check_field("expecting_request", 4'(expecting_request), 4'(oldest.exp_req));
          check_field("expecting_more", 4'(expecting_more), 4'(oldest.exp_more));
          check_field("request_ok", 4'(request_ok), 4'(oldest.req_ok));
          check_field("data_only_next", 4'(data_only_next), 4'(oldest.data_only));
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d reports outstanding", reports_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_packet(directed_tab[i].pkt, directed_tab[i].fixed, directed_tab[i].want);

    // Zero-column header: data never ends the field phase; break out with an eof.
    send_packet(start_word(CMD_OTHER), 1'b0, NO_WANT);
    send_packet(resp_word(RK_DATA, 1'b0, '0), 1'b0, NO_WANT);
    repeat (WALK_COLS) send_packet(resp_word(RK_DATA, 1'b0, '0), 1'b0, NO_WANT);
    send_packet(resp_word(RK_EOF, 1'b0, '0), 1'b0, NO_WANT);

    // Result set walked column by column to the field eof, then closed.
    send_packet(start_word(CMD_OTHER), 1'b0, NO_WANT);
    send_packet(resp_word(RK_DATA, 1'b0, CNT_W'(WALK_COLS)), 1'b0, NO_WANT);
    repeat (WALK_COLS) send_packet(resp_word(RK_DATA, 1'b0, '0), 1'b0, NO_WANT);
    send_packet(resp_word(RK_EOF, 1'b0, '0), 1'b0, NO_WANT);
    send_packet(resp_word(RK_EOF, 1'b0, '0), 1'b0, NO_WANT);

    // Header at the column limit is taken, one past it is refused.
    send_packet(start_word(CMD_OTHER), 1'b0, NO_WANT);
    send_packet(resp_word(RK_DATA, 1'b0, CNT_W'(MAX_COLUMNS)), 1'b0, NO_WANT);
    send_packet(resp_word(RK_ERR, 1'b0, '0), 1'b0, NO_WANT);
    send_packet(start_word(CMD_OTHER), 1'b0, NO_WANT);
    send_packet(resp_word(RK_DATA, 1'b0, CNT_W'(MAX_COLUMNS + 1)), 1'b0, NO_WANT);

    run_traffic(RANDOM_WORDS, 0, 0);
    run_traffic(RANDOM_WORDS, 79, 0);
    run_traffic(RANDOM_WORDS, 0, 79);
    run_traffic(RANDOM_WORDS, 16, 16);

    // let anything extra the block might still emit show up and be flagged
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d words pushed, %0d tracker reports checked, %0d mismatches",
             words_in, reports_out, mismatches);
    $display("tb: directed table, zero-column and %0d-column walks, header limit, 4 idle mixes",
             WALK_COLS);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
